// ===== rtl/drbf_pkg.sv =====
// Shared types and constants for the delimited record byte FIFO.
`default_nettype none

package drbf_pkg;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESP,
        ST_EMIT_RD,
        ST_EMIT_WR,
        ST_TERM
    } state_t;

    // Command codes on the input channel.
    localparam logic [1:0] CMD_PUSH  = 2'd0;
    localparam logic [1:0] CMD_POP   = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    // Status codes on the output channel.
    localparam logic [2:0] STAT_OK      = 3'd0;
    localparam logic [2:0] STAT_FULL    = 3'd1;
    localparam logic [2:0] STAT_EMPTY   = 3'd2;
    localparam logic [2:0] STAT_NOMARK  = 3'd3;
    localparam logic [2:0] STAT_TOOLONG = 3'd4;

    // Configuration register indexes.
    localparam logic CFG_END_MARK = 1'b0;
    localparam logic CFG_MAX_SIZE = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [7:0] END_MARK_RESET = 8'd10;
    localparam logic [6:0] MAX_SIZE_RESET = 7'd64;

    // Hard cap on the words one record pop may produce.
    localparam logic [6:0] MAX_ITEMS = 7'd64;

endpackage

`default_nettype wire

// ===== rtl/delimited_record_byte_fifo_top.sv =====
// Circular byte FIFO with end-mark delimited record extraction.
//
// Usage: the input channel (in_valid/in_stall) carries a command and a byte.
// A push stores data_in and answers with one word. A pop scans the stored
// bytes from the oldest one for end_mark; on success it delivers the record
// bytes, then a zero terminator word with last set, and drops the record.
// Empty, no mark and record too long each answer with one word and leave the
// buffer alone. A clear empties the buffer with one word. Every word carries
// the free space left after the command.
// Rate: push, clear and a pop of an empty buffer are answered from the idle state,
// so pushes can run one per cycle while the receiver does not stall. Any other pop
// first scans through the single memory read port, reading stored bytes up to and
// including the mark (every stored byte when there is none) with a final compare.
// It then sends one reject word, or reads and sends the record bytes one by one
// and then the terminator. Commands are taken one at a time.
// When the receiver stalls, the output register holds its word and the next
// command is not taken until that word has gone.
// Reset zeroes both pointers and restores end_mark (10) and max_record_size
// (64); the byte memory is not cleared and needs no clearing pass.
// The configuration channel (cfg_valid/cfg_ready) is always ready.
`default_nettype none

module delimited_record_byte_fifo_top #(
    parameter int DEPTH = 1024
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    // Command channel
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [1:0] command,
    input  wire logic [7:0] data_in,
    // Result channel
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      data_out,
    output logic            last,
    output logic [2:0]      status,
    output logic [9:0]      free_count,
    // Configuration channel
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic       cfg_index,
    input  wire logic [7:0] cfg_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = (AW > 7) ? AW : 7;
    localparam int FW = (AW > 10) ? AW : 10;
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

    // Advance an address around the ring.
    function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] a);
        ring_inc = (a == LAST_IDX) ? '0 : a + AW'(1);
    endfunction

    // Free space for a given fill level, reported in 10 bits.
    function automatic logic [9:0] free_of(input logic [AW-1:0] c);
        logic [FW-1:0] f;
        f = FW'(LAST_IDX - c);
        free_of = f[9:0];
    endfunction

    drbf_pkg::state_t state_reg, state_next;

    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] count_reg, count_next;
    logic [AW-1:0] scan_idx_reg, scan_idx_next;
    logic [AW-1:0] scan_addr_reg, scan_addr_next;
    logic          chk_vld_reg, chk_vld_next;
    logic [6:0]    len_reg, len_next;
    logic [6:0]    remain_reg, remain_next;
    logic [2:0]    resp_status_reg, resp_status_next;

    logic          out_valid_reg, out_valid_next;
    logic [7:0]    out_data_reg, out_data_next;
    logic          out_last_reg, out_last_next;
    logic [2:0]    out_status_reg, out_status_next;
    logic [9:0]    out_free_reg, out_free_next;

    logic [7:0]    end_mark_reg;
    logic [6:0]    max_size_reg;

    logic [7:0]    mem [0:DEPTH-1];
    logic [7:0]    mem_rdata_reg;
    logic          mem_wen;
    logic          mem_ren;
    logic [AW-1:0] mem_raddr;

    logic          out_free;
    logic          in_acc;
    logic          found;
    logic          scan_end;
    logic          too_long;
    logic [6:0]    limit;
    logic [CW-1:0] scan_len_w;
    logic [CW-1:0] pop_cnt_w;
    logic [AW-1:0] pop_count;

    // Handshake terms.
    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = !((state_reg == drbf_pkg::ST_IDLE) && out_free);
    assign in_acc    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    // Scan compare: the byte read last cycle against the end mark.
    assign found      = chk_vld_reg && (mem_rdata_reg == end_mark_reg);
    assign scan_end   = (scan_idx_reg == count_reg);
    assign limit      = (max_size_reg > drbf_pkg::MAX_ITEMS) ? drbf_pkg::MAX_ITEMS
                                                             : max_size_reg;
    assign scan_len_w = CW'(scan_idx_reg);
    assign too_long   = scan_len_w > CW'(limit);

    // Fill level once the current record and its mark are removed.
    assign pop_cnt_w = CW'(count_reg) - CW'(len_reg);
    assign pop_count = pop_cnt_w[AW-1:0];

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            drbf_pkg::ST_IDLE:
            begin
                if (in_acc && (command == drbf_pkg::CMD_POP) && (count_reg != '0))
                    state_next = drbf_pkg::ST_SCAN;
            end
            drbf_pkg::ST_SCAN:
            begin
                priority if (found)
                begin
                    if (too_long)
                        state_next = drbf_pkg::ST_RESP;
                    else if (scan_idx_reg == AW'(1))
                        state_next = drbf_pkg::ST_TERM;
                    else
                        state_next = drbf_pkg::ST_EMIT_RD;
                end
                else if (scan_end)
                    state_next = drbf_pkg::ST_RESP;
                else
                    state_next = drbf_pkg::ST_SCAN;
            end
            drbf_pkg::ST_RESP:
            begin
                if (out_free)
                    state_next = drbf_pkg::ST_IDLE;
            end
            drbf_pkg::ST_EMIT_RD:
            begin
                if (out_free)
                    state_next = drbf_pkg::ST_EMIT_WR;
            end
            drbf_pkg::ST_EMIT_WR:
            begin
                if (remain_reg == '0)
                    state_next = drbf_pkg::ST_TERM;
                else
                    state_next = drbf_pkg::ST_EMIT_RD;
            end
            drbf_pkg::ST_TERM:
            begin
                if (out_free)
                    state_next = drbf_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = drbf_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath, memory controls and output word.
    always_comb
    begin
        rd_ptr_next      = rd_ptr_reg;
        wr_ptr_next      = wr_ptr_reg;
        count_next       = count_reg;
        scan_idx_next    = scan_idx_reg;
        scan_addr_next   = scan_addr_reg;
        chk_vld_next     = 1'b0;
        len_next         = len_reg;
        remain_next      = remain_reg;
        resp_status_next = resp_status_reg;
        out_valid_next   = out_valid_reg && out_stall;
        out_data_next    = out_data_reg;
        out_last_next    = out_last_reg;
        out_status_next  = out_status_reg;
        out_free_next    = out_free_reg;
        mem_wen          = 1'b0;
        mem_ren          = 1'b0;
        mem_raddr        = scan_addr_reg;

        unique case (state_reg)
            drbf_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    out_data_next   = 8'd0;
                    out_last_next   = 1'b1;
                    out_status_next = drbf_pkg::STAT_OK;
                    out_free_next   = free_of(count_reg);
                    unique case (command)
                        drbf_pkg::CMD_PUSH:
                        begin
                            out_valid_next = 1'b1;
                            if (count_reg == LAST_IDX)
                            begin
                                out_status_next = drbf_pkg::STAT_FULL;
                            end
                            else
                            begin
                                mem_wen       = 1'b1;
                                wr_ptr_next   = ring_inc(wr_ptr_reg);
                                count_next    = count_reg + AW'(1);
                                out_free_next = free_of(count_reg + AW'(1));
                            end
                        end
                        drbf_pkg::CMD_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                out_valid_next  = 1'b1;
                                out_status_next = drbf_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                scan_idx_next  = '0;
                                scan_addr_next = rd_ptr_reg;
                            end
                        end
                        drbf_pkg::CMD_CLEAR:
                        begin
                            out_valid_next = 1'b1;
                            rd_ptr_next    = '0;
                            wr_ptr_next    = '0;
                            count_next     = '0;
                            out_free_next  = free_of('0);
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            drbf_pkg::ST_SCAN:
            begin
                priority if (found)
                begin
                    // Record length including the mark; emit restarts at the head.
                    resp_status_next = drbf_pkg::STAT_TOOLONG;
                    len_next         = scan_len_w[6:0];
                    remain_next      = scan_len_w[6:0] - 7'd1;
                    scan_addr_next   = rd_ptr_reg;
                end
                else if (scan_end)
                begin
                    resp_status_next = drbf_pkg::STAT_NOMARK;
                end
                else
                begin
                    mem_ren        = 1'b1;
                    mem_raddr      = scan_addr_reg;
                    scan_addr_next = ring_inc(scan_addr_reg);
                    scan_idx_next  = scan_idx_reg + AW'(1);
                    chk_vld_next   = 1'b1;
                end
            end
            drbf_pkg::ST_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_data_next   = 8'd0;
                    out_last_next   = 1'b1;
                    out_status_next = resp_status_reg;
                    out_free_next   = free_of(count_reg);
                end
            end
            drbf_pkg::ST_EMIT_RD:
            begin
                // Read the next record byte only once the output slot frees up.
                if (out_free)
                begin
                    mem_ren        = 1'b1;
                    mem_raddr      = scan_addr_reg;
                    scan_addr_next = ring_inc(scan_addr_reg);
                    remain_next    = remain_reg - 7'd1;
                end
            end
            drbf_pkg::ST_EMIT_WR:
            begin
                out_valid_next  = 1'b1;
                out_data_next   = mem_rdata_reg;
                out_last_next   = 1'b0;
                out_status_next = drbf_pkg::STAT_OK;
                out_free_next   = free_of(pop_count);
            end
            drbf_pkg::ST_TERM:
            begin
                // Terminator word; the mark is skipped and the record retired.
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_data_next   = 8'd0;
                    out_last_next   = 1'b1;
                    out_status_next = drbf_pkg::STAT_OK;
                    out_free_next   = free_of(pop_count);
                    rd_ptr_next     = ring_inc(scan_addr_reg);
                    count_next      = pop_count;
                end
            end
            default:
            begin
                out_valid_next = out_valid_reg && out_stall;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= drbf_pkg::ST_IDLE;
            rd_ptr_reg    <= '0;
            wr_ptr_reg    <= '0;
            count_reg     <= '0;
            chk_vld_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_ptr_reg    <= rd_ptr_next;
            wr_ptr_reg    <= wr_ptr_next;
            count_reg     <= count_next;
            chk_vld_reg   <= chk_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload and working registers.
    always_ff @(posedge clk)
    begin
        scan_idx_reg    <= scan_idx_next;
        scan_addr_reg   <= scan_addr_next;
        len_reg         <= len_next;
        remain_reg      <= remain_next;
        resp_status_reg <= resp_status_next;
        out_data_reg    <= out_data_next;
        out_last_reg    <= out_last_next;
        out_status_reg  <= out_status_next;
        out_free_reg    <= out_free_next;
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            end_mark_reg <= drbf_pkg::END_MARK_RESET;
            max_size_reg <= drbf_pkg::MAX_SIZE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                drbf_pkg::CFG_END_MARK: end_mark_reg <= cfg_data;
                drbf_pkg::CFG_MAX_SIZE: max_size_reg <= cfg_data[6:0];
                default:                end_mark_reg <= end_mark_reg;
            endcase
        end
    end

    // Byte store: one write port for pushes, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_wen)
            mem[wr_ptr_reg] <= data_in;
        if (mem_ren)
            mem_rdata_reg <= mem[mem_raddr];
    end

    // Output word.
    assign out_valid  = out_valid_reg;
    assign data_out   = out_data_reg;
    assign last       = out_last_reg;
    assign status     = out_status_reg;
    assign free_count = out_free_reg;

`ifndef SYNTHESIS
    // The fill level always matches the distance between the pointers.
    a_count_matches_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_ptr_reg >= rd_ptr_reg) ? (count_reg == wr_ptr_reg - rd_ptr_reg)
            : (32'(count_reg) == 32'(wr_ptr_reg) + DEPTH - 32'(rd_ptr_reg)))
        else $error("fill level does not match pointers");

    // Pushes and record reads never share the memory in one cycle.
    a_mem_port_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_wen && mem_ren))
        else $error("memory write and read in the same cycle");

    // A record byte is only captured into a free output register.
    a_emit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == drbf_pkg::ST_EMIT_WR) |-> !out_valid_reg)
        else $error("record byte would overwrite a pending word");

    // The final word of every command carries a zero data byte.
    a_last_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last) |-> (data_out == 8'd0))
        else $error("last word with nonzero data");

    // A fresh record byte is always read right before it is emitted.
    a_emit_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == drbf_pkg::ST_EMIT_WR) |-> $past(mem_ren))
        else $error("record byte emitted without a memory read");
`endif

endmodule

`default_nettype wire

// ===== verif/delimited_record_byte_fifo_checker.sv =====
// Checker that predicts and compares the result words of the delimited record byte FIFO.
module delimited_record_byte_fifo_checker (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic       in_stall,
    input  wire logic [1:0] command,
    input  wire logic [7:0] data_in,
    input  wire logic       out_valid,
    input  wire logic       out_stall,
    input  wire logic [7:0] data_out,
    input  wire logic       last,
    input  wire logic [2:0] status,
    input  wire logic [9:0] free_count,
    input  wire logic       cfg_valid,
    input  wire logic       cfg_ready,
    input  wire logic       cfg_index,
    input  wire logic [7:0] cfg_data,
    output int              fail_count,
    output int              pending_words
);
    timeunit 1ns;
    timeprecision 1ps;

    // One result word as the block should deliver it.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic [2:0] status;
        logic [9:0] free;
    } result_word_t;

    // Shadow copy of the FIFO contents, pointers and registers.
    logic [7:0]   byte_ram [0:1023];
    logic [9:0]   head_ptr = '0;
    logic [9:0]   tail_ptr = '0;
    logic [7:0]   mark_byte = drbf_pkg::END_MARK_RESET;
    logic [6:0]   size_limit = drbf_pkg::MAX_SIZE_RESET;
    result_word_t awaited_words [$];
    int           shown_count = 0;

    // Free space with the pointers as they stand; ring arithmetic wraps at 10 bits.
    function automatic logic [9:0] room_left();
        return 10'd1023 - (tail_ptr - head_ptr);
    endfunction

    function automatic void await_word(input logic [7:0] value, input logic is_last,
                                       input logic [2:0] code);
        result_word_t word;
        word.data   = value;
        word.last   = is_last;
        word.status = code;
        word.free   = room_left();
        awaited_words.push_back(word);
    endfunction

    // Work out the words that one accepted command must produce.
    function automatic void predict_command(input logic [1:0] cmd, input logic [7:0] byte_in);
        logic [9:0] used;
        int         rec_len;
        int         cap;
        logic [7:0] rec_bytes [64];
        case (cmd)
            drbf_pkg::CMD_PUSH:
            begin
                if (tail_ptr + 10'd1 == head_ptr)
                    await_word(8'd0, 1'b1, drbf_pkg::STAT_FULL);
                else
                begin
                    byte_ram[tail_ptr] = byte_in;
                    tail_ptr = tail_ptr + 10'd1;
                    await_word(8'd0, 1'b1, drbf_pkg::STAT_OK);
                end
            end
            drbf_pkg::CMD_POP:
            begin
                used = tail_ptr - head_ptr;
                rec_len = 0;
                cap = (size_limit > drbf_pkg::MAX_ITEMS) ? int'(drbf_pkg::MAX_ITEMS)
                                                         : int'(size_limit);
                for (int i = 0; i < int'(used) && rec_len == 0; i++)
                    if (byte_ram[head_ptr + 10'(i)] === mark_byte)
                        rec_len = i + 1;
                if (used == 10'd0)
                    await_word(8'd0, 1'b1, drbf_pkg::STAT_EMPTY);
                else if (rec_len == 0)
                    await_word(8'd0, 1'b1, drbf_pkg::STAT_NOMARK);
                else if (rec_len > cap)
                    await_word(8'd0, 1'b1, drbf_pkg::STAT_TOOLONG);
                else
                begin
                    // Free space in every word counts the record as already removed.
                    for (int i = 0; i < rec_len; i++)
                        rec_bytes[i] = byte_ram[head_ptr + 10'(i)];
                    head_ptr = head_ptr + 10'(rec_len);
                    for (int i = 0; i < rec_len - 1; i++)
                        await_word(rec_bytes[i], 1'b0, drbf_pkg::STAT_OK);
                    await_word(8'd0, 1'b1, drbf_pkg::STAT_OK);
                end
            end
            drbf_pkg::CMD_CLEAR:
            begin
                head_ptr = '0;
                tail_ptr = '0;
                await_word(8'd0, 1'b1, drbf_pkg::STAT_OK);
            end
            default:
                await_word(8'd0, 1'b1, drbf_pkg::STAT_OK);
        endcase
    endfunction

    // Compare delivered words first, then take register writes and new commands.
    always @(posedge clk or negedge rst_n)
    begin
        result_word_t want;
        if (!rst_n)
        begin
            head_ptr = '0;
            tail_ptr = '0;
            mark_byte = drbf_pkg::END_MARK_RESET;
            size_limit = drbf_pkg::MAX_SIZE_RESET;
            awaited_words.delete();
            fail_count = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (awaited_words.size() == 0)
                begin
                    fail_count++;
                    if (shown_count < 10)
                    begin
                        shown_count++;
                        $display("unexpected word: data %0d last %0d status %0d free %0d",
                                 data_out, last, status, free_count);
                    end
                end
                else
                begin
                    want = awaited_words.pop_front();
                    if (data_out !== want.data || last !== want.last ||
                        status !== want.status || free_count !== want.free)
                    begin
                        fail_count++;
                        if (shown_count < 10)
                        begin
                            shown_count++;
                            $display("word mismatch: expected data %0d last %0d status %0d free %0d",
                                     want.data, want.last, want.status, want.free);
                            $display("               got      data %0d last %0d status %0d free %0d",
                                     data_out, last, status, free_count);
                        end
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == drbf_pkg::CFG_END_MARK)
                    mark_byte = cfg_data;
                else
                    size_limit = cfg_data[6:0];
            end
            if (in_valid && !in_stall)
                predict_command(command, data_in);
        end
        pending_words = awaited_words.size();
    end

endmodule

// ===== verif/delimited_record_byte_fifo_top_test.sv =====
// Stimulus, flow control and verdict for the delimited record byte FIFO testbench.
module delimited_record_byte_fifo_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    // The fourth command code has no function and must be ignored.
    localparam logic [1:0] CMD_IGNORED = 2'd3;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic [1:0] command = drbf_pkg::CMD_PUSH;
    logic [7:0] data_in = 8'd0;
    logic       out_stall = 1'b0;
    logic       cfg_valid = 1'b0;
    logic       cfg_index = drbf_pkg::CFG_END_MARK;
    logic [7:0] cfg_data = 8'd0;
    wire        in_stall;
    wire        out_valid;
    wire  [7:0] data_out;
    wire        last;
    wire  [2:0] status;
    wire  [9:0] free_count;
    wire        cfg_ready;
    int         fail_count;
    int         pending_words;

    // Flow control knobs (steady for the sender and the receiver, hold_pending for the receiver) and the current mark.
    bit         steady = 1'b0;
    bit         hold_pending = 1'b0;
    logic [7:0] mark_now = drbf_pkg::END_MARK_RESET;

    delimited_record_byte_fifo_top dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .command(command), .data_in(data_in),
        .out_valid(out_valid), .out_stall(out_stall), .data_out(data_out), .last(last),
        .status(status), .free_count(free_count),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    delimited_record_byte_fifo_checker watch (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .command(command), .data_in(data_in),
        .out_valid(out_valid), .out_stall(out_stall), .data_out(data_out), .last(last),
        .status(status), .free_count(free_count),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .fail_count(fail_count), .pending_words(pending_words)
    );

    always #5 clk = ~clk;

    // Receiver: random stalls, plus one long hold-off on request.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_pending)
            begin
                out_stall <= 1'b1;
                repeat (300) @(posedge clk);
                hold_pending = 1'b0;
            end
            out_stall <= !steady && ($urandom_range(99) < 21);
        end
    end

    // Offer one command word and wait until it is taken, then maybe idle a while.
    task automatic issue(input logic [1:0] cmd, input logic [7:0] byte_in);
        in_valid <= 1'b1;
        command <= cmd;
        data_in <= byte_in;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        while (!steady && $urandom_range(99) < 21)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    // Stop sending and wait for every outstanding result word.
    task automatic await_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_words != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_register(input logic idx, input logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    // Registers change only once the block has gone quiet.
    task automatic apply_settings(input logic [7:0] mark, input logic [7:0] size_byte);
        await_results();
        write_register(drbf_pkg::CFG_END_MARK, mark);
        write_register(drbf_pkg::CFG_MAX_SIZE, size_byte);
        cfg_valid <= 1'b0;
        mark_now = mark;
    endtask

    // Mostly well-formed records with random bodies, mixed with pops and noise.
    task automatic random_traffic(input int item_goal);
        int sent;
        int pick;
        int rec_len;
        sent = 0;
        while (sent < item_goal)
        begin
            pick = $urandom_range(99);
            if (pick < 60)
            begin
                rec_len = ($urandom_range(9) == 0) ? $urandom_range(70) : $urandom_range(6);
                repeat (rec_len)
                    issue(drbf_pkg::CMD_PUSH, 8'($urandom_range(255)));
                sent += rec_len;
                // Now and then the record is left open.
                if ($urandom_range(99) < 85)
                    issue(drbf_pkg::CMD_PUSH, mark_now);
            end
            else if (pick < 88)
                issue(drbf_pkg::CMD_POP, 8'($urandom_range(255)));
            else if (pick < 95)
                issue(drbf_pkg::CMD_PUSH, 8'($urandom_range(255)));
            else if (pick < 98)
                issue(drbf_pkg::CMD_CLEAR, 8'($urandom_range(255)));
            else
                issue(CMD_IGNORED, 8'($urandom_range(255)));
            sent++;
        end
    endtask

    // Watchdog for a hung block.
    initial
    begin
        #30_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed cases with the reset register values.
        issue(drbf_pkg::CMD_POP, 8'h00);
        issue(drbf_pkg::CMD_PUSH, 8'h00);
        issue(drbf_pkg::CMD_PUSH, 8'hFF);
        issue(drbf_pkg::CMD_POP, 8'hFF);
        issue(drbf_pkg::CMD_PUSH, drbf_pkg::END_MARK_RESET);
        issue(drbf_pkg::CMD_POP, 8'h3C);
        issue(drbf_pkg::CMD_POP, 8'h00);
        issue(CMD_IGNORED, 8'hA5);
        issue(drbf_pkg::CMD_PUSH, drbf_pkg::END_MARK_RESET);
        issue(drbf_pkg::CMD_POP, 8'h81);
        issue(drbf_pkg::CMD_PUSH, 8'h55);
        issue(drbf_pkg::CMD_CLEAR, 8'h5A);
        issue(drbf_pkg::CMD_POP, 8'h00);

        // A four byte record is too long for a limit of three and fits a limit of four.
        apply_settings(drbf_pkg::END_MARK_RESET, 8'd3);
        issue(drbf_pkg::CMD_PUSH, 8'h01);
        issue(drbf_pkg::CMD_PUSH, 8'h02);
        issue(drbf_pkg::CMD_PUSH, 8'h03);
        issue(drbf_pkg::CMD_PUSH, drbf_pkg::END_MARK_RESET);
        issue(drbf_pkg::CMD_POP, 8'hC3);
        apply_settings(drbf_pkg::END_MARK_RESET, 8'd4);
        issue(drbf_pkg::CMD_POP, 8'h7E);

        // Keep pushing records behind a long receiver hold-off, then pop them back.
        apply_settings(drbf_pkg::END_MARK_RESET, 8'(drbf_pkg::MAX_SIZE_RESET));
        issue(drbf_pkg::CMD_CLEAR, 8'h00);
        hold_pending = 1'b1;
        for (int i = 0; i < 24; i++)
            issue(drbf_pkg::CMD_PUSH, (i % 6 == 5) ? mark_now : 8'($urandom_range(255)));
        repeat (8)
            issue(drbf_pkg::CMD_POP, 8'($urandom_range(255)));

        // Random phases over a range of register settings.
        apply_settings(8'h00, 8'd1);
        steady = 1'b1;
        random_traffic(30);
        steady = 1'b0;
        apply_settings(8'hFF, 8'hFF);
        random_traffic(30);
        apply_settings(8'($urandom_range(255)), 8'($urandom_range(1, 64)));
        random_traffic(30);
        apply_settings(8'h41, 8'h00);
        random_traffic(30);
        apply_settings(8'($urandom_range(255)), 8'hC0);
        random_traffic(30);

        await_results();
        repeat (20) @(posedge clk);
        if (fail_count == 0 && pending_words == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
